[src/fcgl_pkg.sv]
// Package of the floppy card glue logic: item and result types, command and
// access codes, decode constants and the small helper functions.
// No dependencies.
`default_nettype none

package fcgl_pkg;

  localparam int ROM_BYTES   = 8192;
  localparam int ADDR_W      = 21;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [2:0] {
    CmdSetAddr  = 3'd0,
    CmdMemRead  = 3'd1,
    CmdMemWrite = 3'd2,
    CmdCtlRead  = 3'd3,
    CmdCtlWrite = 3'd4,
    CmdIrq      = 3'd5,
    CmdDrq      = 3'd6,
    CmdTick     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KindNone      = 2'd0,
    KindRomRead   = 2'd1,
    KindPortRead  = 2'd2,
    KindPortWrite = 2'd3
  } kind_t;

  localparam logic [CFG_INDEX_W-1:0] RegAltDecode = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] RegCruBase   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] RegMotorTick = 2'd2;

  localparam logic [2:0] CtlCardEn   = 3'd0;
  localparam logic [2:0] CtlMotor    = 3'd1;
  localparam logic [2:0] CtlWait     = 3'd2;
  localparam logic [2:0] CtlHeadLoad = 3'd3;
  localparam logic [2:0] CtlDrive0   = 3'd4;
  localparam logic [2:0] CtlDrive1   = 3'd5;
  localparam logic [2:0] CtlDrive2   = 3'd6;
  localparam logic [2:0] CtlSide     = 3'd7;

  localparam logic [ADDR_W-1:0] WIN_MASK_STD  = 21'h07e000;
  localparam logic [ADDR_W-1:0] WIN_MATCH_STD = 21'h074000;
  localparam logic [ADDR_W-1:0] WIN_MASK_ALT  = 21'h1fe000;
  localparam logic [ADDR_W-1:0] WIN_MATCH_ALT = 21'h174000;
  localparam logic [ADDR_W-1:0] CHIP_MASK     = 21'h001ff1;
  localparam logic [ADDR_W-1:0] CHIP_MATCH    = 21'h001ff0;
  localparam logic [ADDR_W-1:0] PORT_MASK     = 21'h000009;
  localparam logic [ADDR_W-1:0] PORT_RD_MATCH = 21'h000000;
  localparam logic [ADDR_W-1:0] PORT_WR_MATCH = 21'h000008;

  localparam logic [CFG_DATA_W-1:0] CRU_BASE_RESET    = 16'h1100;
  localparam logic [CFG_DATA_W-1:0] MOTOR_TICKS_RESET = 16'd4230;

  localparam logic [1:0] DRIVE_NONE = 2'd3;

  typedef struct packed {
    logic                  alt_host_decode;
    logic [CFG_DATA_W-1:0] cru_base;
    logic [CFG_DATA_W-1:0] motor_ticks;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic              bit_value;
  } item_t;

  typedef struct packed {
    logic        ready_res;
    kind_t       access_kind;
    logic [12:0] rom_offset;
    logic [1:0]  fdc_port;
    logic [7:0]  write_data;
    logic [7:0]  status_byte;
    logic [1:0]  drive_index;
    logic        side_select;
    logic        motor_on;
  } res_t;

  function automatic logic [1:0] pick_drive(input logic [2:0] bits);
    if (bits[2]) return 2'd2;
    if (bits[1]) return 2'd1;
    if (bits[0]) return 2'd0;
    return DRIVE_NONE;
  endfunction

  // Wrap a 13-bit window offset into the ROM by restoring subtraction.
  function automatic logic [12:0] rom_wrap(input logic [12:0] off);
    logic [31:0] r;
    r = 32'(off);
    for (int k = 2; k >= 0; k--) begin
      if (r >= (32'(ROM_BYTES) << k)) begin
        r = r - (32'(ROM_BYTES) << k);
      end
    end
    return r[12:0];
  endfunction

endpackage

`default_nettype wire

[src/fcgl_if.sv]
// Handshake channels of the floppy card glue logic: bus item in, result out.
// Depends on fcgl_pkg.
`default_nettype none

interface fcgl_bus_if;
  logic                       valid;
  logic                       ready;
  fcgl_pkg::cmd_t             cmd;
  logic [fcgl_pkg::ADDR_W-1:0] address;
  logic [7:0]                 data;
  logic                       bit_value;

  modport source (output valid, cmd, address, data, bit_value, input ready);
  modport sink (input valid, cmd, address, data, bit_value, output ready);
endinterface

interface fcgl_res_if;
  logic                valid;
  logic                ready;
  logic                ready_res;
  fcgl_pkg::kind_t     access_kind;
  logic [12:0]         rom_offset;
  logic [1:0]          fdc_port;
  logic [7:0]          write_data;
  logic [7:0]          status_byte;
  logic [1:0]          drive_index;
  logic                side_select;
  logic                motor_on;

  modport source (output valid, ready_res, access_kind, rom_offset, fdc_port, write_data,
                  status_byte, drive_index, side_select, motor_on, input ready);
  modport sink (input valid, ready_res, access_kind, rom_offset, fdc_port, write_data,
                status_byte, drive_index, side_select, motor_on, output ready);
endinterface

`default_nettype wire

[src/floppy_card_glue_logic_top.sv]
// Floppy card glue logic, top level: input register, configuration registers,
// result register around fcgl_core. Depends on fcgl_pkg, fcgl_if, fcgl_core.
//
// Use:
//   bus    : valid/ready channel of bus events and millisecond ticks (cmd,
//            address, data, bit_value). An item is taken when valid and ready
//            are both high at a rising edge of clk.
//   result : valid/ready channel, exactly one result item per bus item, in
//            order: READY line, access kind, ROM offset, port, write byte,
//            status byte, drive index, side and motor state.
//   cfg_*  : register write port (0 alt_host_decode, 1 cru_base,
//            2 motor_ticks); write only while no item is in flight.
// Path: an item taken goes into the input register, then into the result
// register. Throughput: one item per cycle while the receiver takes the
// results; the decode and the state update sit between the two registers.
// Reset (rst, synchronous): pipeline empty, card state cleared, registers at
// their defaults. When the receiver stalls, the result register holds; the
// input register takes one more item only if empty, then bus.ready drops.
`default_nettype none

module floppy_card_glue_logic_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  fcgl_bus_if.sink                                 bus,
  fcgl_res_if.source                               result,
  input  wire logic                                cfg_wr_en,
  input  wire logic [fcgl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [fcgl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fcgl_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  res_t  res;
  res_t  res_q;
  logic  res_valid;
  logic  advance;

  assign advance   = item_valid && (!res_valid || result.ready);
  assign bus.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alt_host_decode <= 1'b0;
      cfg.cru_base        <= CRU_BASE_RESET;
      cfg.motor_ticks     <= MOTOR_TICKS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegAltDecode: cfg.alt_host_decode <= cfg_wdata[0];
        RegCruBase:   cfg.cru_base        <= cfg_wdata;
        RegMotorTick: cfg.motor_ticks     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (bus.ready) begin
      item_valid <= bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bus.ready && bus.valid) begin
      item.cmd       <= bus.cmd;
      item.address   <= bus.address;
      item.data      <= bus.data;
      item.bit_value <= bus.bit_value;
    end
  end

  fcgl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign result.valid       = res_valid;
  assign result.ready_res   = res_q.ready_res;
  assign result.access_kind = res_q.access_kind;
  assign result.rom_offset  = res_q.rom_offset;
  assign result.fdc_port    = res_q.fdc_port;
  assign result.write_data  = res_q.write_data;
  assign result.status_byte = res_q.status_byte;
  assign result.drive_index = res_q.drive_index;
  assign result.side_select = res_q.side_select;
  assign result.motor_on    = res_q.motor_on;

endmodule

`default_nettype wire

[src/fcgl_core.sv]
// Card state and decode: address window, control bits, motor monoflop and
// the result of one item. Depends on fcgl_pkg.
`default_nettype none

module fcgl_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire fcgl_pkg::cfg_t  cfg,
  input  wire fcgl_pkg::item_t item,
  output fcgl_pkg::res_t       res
);
  import fcgl_pkg::*;

  logic [ADDR_W-1:0] latched_address, latched_address_next;
  logic              in_window, in_window_next;
  logic              chip_selected, chip_selected_next;
  logic              card_enabled, card_enabled_next;
  logic              wait_enabled, wait_enabled_next;
  logic [2:0]        drive_bits, drive_bits_next;
  logic [1:0]        current_drive, current_drive_next;
  logic              side_bit, side_bit_next;
  logic              last_motor_bit, last_motor_bit_next;
  logic              motor_spinning, motor_spinning_next;
  logic [15:0]       motor_countdown, motor_countdown_next;
  logic              irq_level, irq_level_next;
  logic              drq_level, drq_level_next;

  logic              active;
  logic              cru_hit;
  logic [2:0]        bitno;
  logic [ADDR_W-1:0] win_mask;
  logic [ADDR_W-1:0] win_match;
  logic              hit_window;

  always_comb begin
    latched_address_next = latched_address;
    in_window_next       = in_window;
    chip_selected_next   = chip_selected;
    card_enabled_next    = card_enabled;
    wait_enabled_next    = wait_enabled;
    drive_bits_next      = drive_bits;
    current_drive_next   = current_drive;
    side_bit_next        = side_bit;
    last_motor_bit_next  = last_motor_bit;
    motor_spinning_next  = motor_spinning;
    motor_countdown_next = motor_countdown;
    irq_level_next       = irq_level;
    drq_level_next       = drq_level;
    res                  = '0;

    active     = in_window && card_enabled;
    cru_hit    = (item.address[15:8] == cfg.cru_base[15:8]) && (cfg.cru_base[7:0] == 8'h00);
    bitno      = item.address[3:1];
    win_mask   = cfg.alt_host_decode ? WIN_MASK_ALT : WIN_MASK_STD;
    win_match  = cfg.alt_host_decode ? WIN_MATCH_ALT : WIN_MATCH_STD;
    hit_window = (item.address & win_mask) == win_match;

    case (item.cmd)
      CmdSetAddr: begin
        latched_address_next = item.address;
        in_window_next       = hit_window;
        if (hit_window && card_enabled) begin
          chip_selected_next = (item.address & CHIP_MASK) == CHIP_MATCH;
        end
      end
      CmdMemRead: begin
        if (active) begin
          if (chip_selected && (latched_address & PORT_MASK) == PORT_RD_MATCH) begin
            res.access_kind = KindPortRead;
            res.fdc_port    = item.address[2:1];
          end else begin
            res.access_kind = KindRomRead;
            res.rom_offset  = rom_wrap(latched_address[12:0]);
          end
        end
      end
      CmdMemWrite: begin
        if (active && chip_selected && (latched_address & PORT_MASK) == PORT_WR_MATCH) begin
          res.access_kind = KindPortWrite;
          res.fdc_port    = item.address[2:1];
          res.write_data  = item.data;
        end
      end
      CmdCtlRead: begin
        if (cru_hit && item.address[2:0] == 3'd0) begin
          res.status_byte = {side_bit, 1'b1, 1'b0, !motor_spinning, drive_bits, 1'b0};
        end
      end
      CmdCtlWrite: begin
        if (cru_hit) begin
          case (bitno)
            CtlCardEn: card_enabled_next = item.bit_value;
            CtlMotor: begin
              if (item.bit_value && !last_motor_bit) begin
                motor_spinning_next  = 1'b1;
                motor_countdown_next = cfg.motor_ticks;
              end
              last_motor_bit_next = item.bit_value;
            end
            CtlWait: wait_enabled_next = item.bit_value;
            CtlHeadLoad: ;
            CtlDrive0, CtlDrive1, CtlDrive2: begin
              drive_bits_next[bitno[1:0]] = item.bit_value;
              current_drive_next          = pick_drive(drive_bits_next);
            end
            CtlSide: side_bit_next = item.bit_value;
            default: ;
          endcase
        end
      end
      CmdIrq: irq_level_next = item.bit_value;
      CmdDrq: drq_level_next = item.bit_value;
      CmdTick: begin
        if (motor_spinning) begin
          if (motor_countdown <= 16'd1) begin
            motor_countdown_next = '0;
            motor_spinning_next  = 1'b0;
          end else begin
            motor_countdown_next = motor_countdown - 16'd1;
          end
        end
      end
      default: ;
    endcase

    res.ready_res   = !(chip_selected_next && wait_enabled_next && !drq_level_next &&
                        !irq_level_next && motor_spinning_next);
    res.drive_index = current_drive_next;
    res.side_select = side_bit_next;
    res.motor_on    = motor_spinning_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_address <= '0;
      in_window       <= 1'b0;
      chip_selected   <= 1'b0;
      card_enabled    <= 1'b0;
      wait_enabled    <= 1'b0;
      drive_bits      <= '0;
      current_drive   <= '0;
      side_bit        <= 1'b0;
      last_motor_bit  <= 1'b0;
      motor_spinning  <= 1'b0;
      motor_countdown <= '0;
      irq_level       <= 1'b0;
      drq_level       <= 1'b0;
    end else if (step) begin
      latched_address <= latched_address_next;
      in_window       <= in_window_next;
      chip_selected   <= chip_selected_next;
      card_enabled    <= card_enabled_next;
      wait_enabled    <= wait_enabled_next;
      drive_bits      <= drive_bits_next;
      current_drive   <= current_drive_next;
      side_bit        <= side_bit_next;
      last_motor_bit  <= last_motor_bit_next;
      motor_spinning  <= motor_spinning_next;
      motor_countdown <= motor_countdown_next;
      irq_level       <= irq_level_next;
      drq_level       <= drq_level_next;
    end
  end

endmodule

`default_nettype wire

[src/fcgl_checker.sv]
// Port-level checks of the floppy card glue logic and their bind to the top
// level. Depends on fcgl_pkg and floppy_card_glue_logic_top.
`default_nettype none

module fcgl_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            res_valid,
  input wire logic            res_ready,
  input wire logic            ready_res,
  input wire fcgl_pkg::kind_t access_kind,
  input wire logic [12:0]     rom_offset,
  input wire logic [1:0]      fdc_port,
  input wire logic [7:0]      write_data,
  input wire logic            motor_on
);
  import fcgl_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(access_kind) && $stable(rom_offset))
    else $error("stalled result changed");

  a_wait_needs_motor: assert property (@(posedge clk) disable iff (rst)
    res_valid && !ready_res |-> motor_on)
    else $error("wait state without running motor");

  a_rom_offset_only_rom: assert property (@(posedge clk) disable iff (rst)
    res_valid && access_kind != KindRomRead |-> rom_offset == 13'd0)
    else $error("ROM offset on a non-ROM access");

  a_port_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && access_kind != KindPortWrite |-> write_data == 8'd0 &&
    (access_kind == KindPortRead || fdc_port == 2'd0))
    else $error("port fields on a non-port access");

endmodule

bind floppy_card_glue_logic_top fcgl_checker u_fcgl_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .ready_res   (result.ready_res),
  .access_kind (result.access_kind),
  .rom_offset  (result.rom_offset),
  .fdc_port    (result.fdc_port),
  .write_data  (result.write_data),
  .motor_on    (result.motor_on)
);

`default_nettype wire
